/* design/mcad_pkg.sv */
package mcad_pkg;

  // Sizes of the channel store and of the converter samples.
  localparam int CHANNELS    = 32;
  localparam int SAMPLE_BITS = 12;

  // Field widths of the item ports.
  localparam int CHANNEL_W = 5;
  localparam int LEVEL_W   = 5;
  localparam int COUNT_W   = 8;

  // Quantizer constants: full scale is 2^SAMPLE_BITS - 1.
  localparam int STEPS_FINE   = 24;
  localparam int STEPS_COARSE = 8;
  localparam int PROD_W       = SAMPLE_BITS + 5;
  localparam int FULL_SCALE   = (1 << SAMPLE_BITS) - 1;

  // Channel store index width.
  localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // Depth of the queue between the quantizer and the state update.
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

  // Reset value of the repeat target register.
  localparam logic [COUNT_W-1:0] TARGET_RESET = COUNT_W'(4);

  // A quantized reading on its way to the state update.
  typedef struct packed {
    logic [CHANNEL_W-1:0] channel;
    logic [LEVEL_W-1:0]   level;
  } mcad_item_t;

endpackage

/* design/multichannel_analog_debouncer.sv */
// A beat passes through the input register, the queue and the output register in that order.
// One beat per cycle while the queue and output are not stalled; the channel state is read,
// updated and written back in the same cycle, so beats on the same channel can follow each other directly.
// Reset (synchronous, active high) empties the queue and output, sets repeat_target
// to 4 and marks every channel entry as zero at once; no clearing pass is needed.
module multichannel_analog_debouncer import mcad_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [COUNT_W-1:0]     cfg_wdata,
  input  logic                   push,
  output logic                   full,
  input  logic [CHANNEL_W-1:0]   channel,
  input  logic [SAMPLE_BITS-1:0] sample,
  input  logic                   coarse_scale,
  output logic                   empty,
  input  logic                   pop,
  output logic [LEVEL_W-1:0]     stable_value,
  output logic                   changed,
  output logic [CHANNEL_W-1:0]   channel_out
);

  logic       fq_valid;
  logic       fq_ready;
  mcad_item_t fq_item;
  logic       qb_valid;
  logic       qb_ready;
  mcad_item_t qb_item;

  // Quantizer front end.
  mcad_front u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .channel      (channel),
    .sample       (sample),
    .coarse_scale (coarse_scale),
    .item_valid   (fq_valid),
    .item         (fq_item),
    .item_ready   (fq_ready)
  );

  // Decoupling queue.
  mcad_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (fq_valid),
    .wr_ready (fq_ready),
    .wr_item  (fq_item),
    .rd_valid (qb_valid),
    .rd_ready (qb_ready),
    .rd_item  (qb_item)
  );

  // Per-channel debounce state and result register.
  mcad_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .item_valid   (qb_valid),
    .item_ready   (qb_ready),
    .item         (qb_item),
    .empty        (empty),
    .pop          (pop),
    .stable_value (stable_value),
    .changed      (changed),
    .channel_out  (channel_out)
  );

endmodule

/* design/mcad_front.sv */
module mcad_front import mcad_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  output logic                   full,
  input  logic [CHANNEL_W-1:0]   channel,
  input  logic [SAMPLE_BITS-1:0] sample,
  input  logic                   coarse_scale,
  output logic                   item_valid,
  output mcad_item_t             item,
  input  logic                   item_ready
);

  logic                 f_valid;
  logic [CHANNEL_W-1:0] f_channel;
  logic [PROD_W-1:0]    f_product;
  logic                 accept;
  logic [LEVEL_W-1:0]   quot_low;
  logic [PROD_W-1:0]    remainder;
  logic [LEVEL_W-1:0]   level;

  // The input register stalls only when the queue behind it cannot take its beat.
  assign full   = f_valid && !item_ready;
  assign accept = push && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (!full) begin
      f_valid <= push;
    end
  end

  // Scale the sample by the number of steps in the first stage.
  always_ff @(posedge clk) begin
    if (accept) begin
      f_channel <= channel;
      f_product <= PROD_W'(sample) *
                   PROD_W'(coarse_scale ? STEPS_COARSE : STEPS_FINE);
    end
  end

  // Divide by full scale: dividing by 2^SAMPLE_BITS lands at most one short,
  // so a single compare on the remainder fixes the quotient.
  always_comb begin
    quot_low  = LEVEL_W'(f_product >> SAMPLE_BITS);
    remainder = f_product - (PROD_W'(quot_low) << SAMPLE_BITS) + PROD_W'(quot_low);
    level     = (remainder >= PROD_W'(FULL_SCALE)) ? quot_low + LEVEL_W'(1) : quot_low;
  end

  assign item_valid    = f_valid;
  assign item.channel  = f_channel;
  assign item.level    = level;

endmodule

/* design/mcad_fifo.sv */
module mcad_fifo import mcad_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       wr_valid,
  output logic       wr_ready,
  input  mcad_item_t wr_item,
  output logic       rd_valid,
  input  logic       rd_ready,
  output mcad_item_t rd_item
);

  mcad_item_t              slots [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]   wr_ptr;
  logic [FIFO_PTR_W-1:0]   rd_ptr;
  logic [FIFO_PTR_W:0]     count;
  logic                    do_wr;
  logic                    do_rd;

  assign wr_ready = (count != (FIFO_PTR_W+1)'(FIFO_DEPTH));
  assign rd_valid = (count != '0);
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;
  assign rd_item  = slots[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + FIFO_PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + FIFO_PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + (FIFO_PTR_W+1)'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - (FIFO_PTR_W+1)'(1);
      end
    end
  end

  // Slot storage.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_item;
    end
  end

`ifndef NO_ASSERTIONS
  // The fill count never passes the depth.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (FIFO_PTR_W+1)'(FIFO_DEPTH))
    else $error("queue fill count beyond depth");

  // A read without a write drops the fill count by one.
  a_count_read: assert property (@(posedge clk) disable iff (rst)
    (do_rd && !do_wr) |=> count == $past(count) - (FIFO_PTR_W+1)'(1))
    else $error("queue fill count did not follow a read");
`endif

endmodule

/* design/mcad_back.sv */
module mcad_back import mcad_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [COUNT_W-1:0]   cfg_wdata,
  input  logic                 item_valid,
  output logic                 item_ready,
  input  mcad_item_t           item,
  output logic                 empty,
  input  logic                 pop,
  output logic [LEVEL_W-1:0]   stable_value,
  output logic                 changed,
  output logic [CHANNEL_W-1:0] channel_out
);

  logic [COUNT_W-1:0]   repeat_target;
  logic [CHANNELS-1:0]  ent_valid;
  logic [LEVEL_W-1:0]   stable_mem [CHANNELS];
  logic [LEVEL_W-1:0]   cand_mem   [CHANNELS];
  logic [COUNT_W-1:0]   cnt_mem    [CHANNELS];

  logic                 o_valid;
  logic [LEVEL_W-1:0]   o_stable;
  logic                 o_changed;
  logic [CHANNEL_W-1:0] o_channel;

  logic                 take;
  logic                 in_range;
  logic [CH_IDX_W-1:0]  idx;
  logic [LEVEL_W-1:0]   old_stable;
  logic [LEVEL_W-1:0]   old_cand;
  logic [COUNT_W-1:0]   old_cnt;
  logic [COUNT_W-1:0]   cnt_inc;
  logic [LEVEL_W-1:0]   stable_next;
  logic [LEVEL_W-1:0]   cand_next;
  logic [COUNT_W-1:0]   cnt_next;
  logic                 promote;

  // The output register frees up when its beat is popped.
  assign item_ready = !o_valid || pop;
  assign take       = item_valid && item_ready;
  assign empty      = !o_valid;

  // Repeat target register.
  always_ff @(posedge clk) begin
    if (rst) begin
      repeat_target <= TARGET_RESET;
    end else if (cfg_we) begin
      repeat_target <= cfg_wdata;
    end
  end

  // Read the channel entry; an entry not written since reset reads as zero.
  always_comb begin
    in_range   = (32'(item.channel) < CHANNELS);
    idx        = CH_IDX_W'(item.channel);
    old_stable = ent_valid[idx] ? stable_mem[idx] : '0;
    old_cand   = ent_valid[idx] ? cand_mem[idx]   : '0;
    old_cnt    = ent_valid[idx] ? cnt_mem[idx]    : '0;
  end

  // Debounce decision for one reading.
  always_comb begin
    cnt_inc     = old_cnt + COUNT_W'(1);
    stable_next = old_stable;
    cand_next   = old_cand;
    cnt_next    = '0;
    promote     = 1'b0;
    if (item.level == old_stable) begin
      cnt_next = '0;
    end else if (item.level == old_cand) begin
      if (cnt_inc == repeat_target) begin
        promote     = 1'b1;
        stable_next = old_cand;
        cnt_next    = '0;
      end else begin
        cnt_next = cnt_inc;
      end
    end else begin
      cand_next = item.level;
      cnt_next  = '0;
    end
  end

  // Entry valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      ent_valid <= '0;
    end else if (take && in_range) begin
      ent_valid[idx] <= 1'b1;
    end
  end

  // Channel state write-back.
  always_ff @(posedge clk) begin
    if (take && in_range) begin
      stable_mem[idx] <= stable_next;
      cand_mem[idx]   <= cand_next;
      cnt_mem[idx]    <= cnt_next;
    end
  end

  // Output register holds the result beat until it is popped.
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (item_ready) begin
      o_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      o_stable  <= in_range ? stable_next : '0;
      o_changed <= in_range && (stable_next != old_stable);
      o_channel <= item.channel;
    end
  end

  assign stable_value = o_stable;
  assign changed      = o_changed;
  assign channel_out  = o_channel;

`ifndef NO_ASSERTIONS
  // After a promotion the channel's repeat count is clear.
  a_promote_clears: assert property (@(posedge clk) disable iff (rst)
    (take && in_range && promote) |=> cnt_mem[$past(idx)] == '0)
    else $error("repeat count not cleared after promotion");

  // A changed result always comes from a promotion.
  a_changed_source: assert property (@(posedge clk) disable iff (rst)
    (take && !(in_range && promote)) |=> !o_changed)
    else $error("changed flag set without a promotion");
`endif

endmodule
